// ===== src/gdad_pkg.sv =====
// shared types, constants and calendar helpers for the date shifter
`timescale 1ns / 1ps
package gdad_pkg;

	localparam int          DAYS_YEAR = 365;
	localparam int          DAYS_LEAP = 366;
	localparam logic [3:0]  MONTHS    = 4'd12;
	localparam logic [3:0]  FEBRUARY  = 4'd2;
	localparam logic [4:0]  FEB_BASE  = 5'd28;
	localparam logic [3:0]  WEEK_DAYS = 4'd7;

	localparam logic [2:0] DAY_MOD7 [32] = '{
		3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0,
		3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1,
		3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2,
		3'd3, 3'd4, 3'd5, 3'd6, 3'd0, 3'd1, 3'd2, 3'd3
	};

	typedef enum logic [3:0] {
		S_IDLE,
		S_FYEAR,
		S_FMON,
		S_FDAY,
		S_OFFS,
		S_CHKLO,
		S_CHKHI,
		S_RYEAR,
		S_RMON,
		S_DONE
	} state_t;

	typedef enum logic [1:0] {
		RES_INVALID,
		RES_RANGE,
		RES_OK
	} res_kind_t;

	typedef enum logic [1:0] {
		ALU_HOLD,
		ALU_CLR,
		ALU_ADD,
		ALU_SUB
	} alu_cmd_t;

	typedef enum logic [1:0] {
		CAL_HOLD,
		CAL_INIT,
		CAL_YEAR,
		CAL_MONTH
	} cal_cmd_t;

	typedef enum logic [2:0] {
		B_YLEN,
		B_MLEN,
		B_DAY,
		B_OFF,
		B_ZERO,
		B_LAST
	} bsel_t;

	typedef struct packed {
		alu_cmd_t alu;
		cal_cmd_t cal;
		bsel_t    bsel;
		logic     wd_clr;
		logic     wd_add;
		logic     cap_serial;
		logic     load_out;
	} ctl_t;

	typedef struct packed {
		logic yr_ok;
		logic y_eq;
		logic month_ok;
		logic m_eq;
		logic day_ok;
		logic gt;
		logic m_lt12;
	} stat_t;

	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] d;
		case (m)
			FEBRUARY: begin
				d = leap ? 5'd29 : 5'd28;
			end
			4'd4, 4'd6, 4'd9, 4'd11: begin
				d = 5'd30;
			end
			default: begin
				d = 5'd31;
			end
		endcase
		return d;
	endfunction

endpackage

// ===== src/gdad_if.sv =====
// handshake channels for date requests and results
`timescale 1ns / 1ps
interface gdad_req_if;
	logic               valid;
	logic               ready;
	logic [4:0]         day;
	logic [3:0]         month;
	logic [11:0]        year;
	logic signed [17:0] day_offset;

	modport source (output valid, day, month, year, day_offset, input ready);
	modport sink (input valid, day, month, year, day_offset, output ready);
endinterface

interface gdad_rsp_if;
	logic        valid;
	logic        ready;
	logic        date_valid;
	logic [16:0] serial_day;
	logic [2:0]  weekday;
	logic [4:0]  result_day;
	logic [3:0]  result_month;
	logic [11:0] result_year;
	logic        range_error;

	modport source (output valid, date_valid, serial_day, weekday, result_day,
		result_month, result_year, range_error, input ready);
	modport sink (input valid, date_valid, serial_day, weekday, result_day,
		result_month, result_year, range_error, output ready);
endinterface

// ===== src/gdad_alu.sv =====
// shared accumulator with one add/subtract and one signed compare
`timescale 1ns / 1ps
module gdad_alu import gdad_pkg::*; #(
	parameter int AW = 22
) (
	input  logic                 clk,
	input  alu_cmd_t             cmd,
	input  logic signed [AW-1:0] b,
	output logic signed [AW-1:0] acc,
	output logic                 gt
);

	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] sum;

	assign sum = (cmd == ALU_SUB) ? (acc_q - b) : (acc_q + b);
	assign gt  = acc_q > b;
	assign acc = acc_q;

	always_ff @(posedge clk) begin
		case (cmd)
			ALU_CLR: begin
				acc_q <= '0;
			end
			ALU_ADD, ALU_SUB: begin
				acc_q <= sum;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

endmodule

// ===== src/gdad_cal.sv =====
// year and month stepping counters with leap tracking by residues
`timescale 1ns / 1ps
module gdad_cal import gdad_pkg::*; #(
	parameter int BASE_YEAR = 1900,
	parameter int YEAR_SPAN = 256,
	localparam int YW = $clog2(BASE_YEAR + YEAR_SPAN + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cal_cmd_t      cmd,
	output logic [YW-1:0] year,
	output logic [3:0]    month,
	output logic          leap,
	output logic [4:0]    mlen
);

	localparam logic [1:0] R4_INIT   = 2'(BASE_YEAR % 4);
	localparam logic [6:0] R100_INIT = 7'(BASE_YEAR % 100);
	localparam logic [8:0] R400_INIT = 9'(BASE_YEAR % 400);

	logic [YW-1:0] year_q;
	logic [3:0]    month_q;
	logic [1:0]    r4_q;
	logic [6:0]    r100_q;
	logic [8:0]    r400_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q  <= YW'(BASE_YEAR);
			month_q <= 4'd1;
			r4_q    <= R4_INIT;
			r100_q  <= R100_INIT;
			r400_q  <= R400_INIT;
		end else begin
			case (cmd)
				CAL_INIT: begin
					year_q  <= YW'(BASE_YEAR);
					month_q <= 4'd1;
					r4_q    <= R4_INIT;
					r100_q  <= R100_INIT;
					r400_q  <= R400_INIT;
				end
				CAL_YEAR: begin
					year_q <= year_q + 1'b1;
					r4_q   <= r4_q + 1'b1;
					r100_q <= (r100_q == 7'd99) ? 7'd0 : (r100_q + 1'b1);
					r400_q <= (r400_q == 9'd399) ? 9'd0 : (r400_q + 1'b1);
				end
				CAL_MONTH: begin
					month_q <= month_q + 1'b1;
				end
				default: begin
					year_q <= year_q;
				end
			endcase
		end
	end

	assign leap  = ((r4_q == 2'd0) && (r100_q != 7'd0)) || (r400_q == 9'd0);
	assign mlen  = month_days(month_q, leap);
	assign year  = year_q;
	assign month = month_q;

endmodule

// ===== src/gdad_fsm.sv =====
// sequencer driving the shared accumulator and the calendar counters
`timescale 1ns / 1ps
module gdad_fsm import gdad_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  logic      out_free,
	input  stat_t     st,
	output ctl_t      ctl,
	output logic      in_ready,
	output res_kind_t kind
);

	state_t    state_q, state_d;
	res_kind_t kind_q, kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= RES_INVALID;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) state_d = S_FYEAR;
			end
			S_FYEAR: begin
				if (!st.yr_ok) begin
					state_d = S_DONE;
					kind_d  = RES_INVALID;
				end else if (st.y_eq) begin
					state_d = S_FMON;
				end
			end
			S_FMON: begin
				if (!st.month_ok) begin
					state_d = S_DONE;
					kind_d  = RES_INVALID;
				end else if (st.m_eq) begin
					if (st.day_ok) begin
						state_d = S_FDAY;
					end else begin
						state_d = S_DONE;
						kind_d  = RES_INVALID;
					end
				end
			end
			S_FDAY: begin
				state_d = S_OFFS;
			end
			S_OFFS: begin
				state_d = S_CHKLO;
			end
			S_CHKLO: begin
				if (!st.gt) begin
					state_d = S_DONE;
					kind_d  = RES_RANGE;
				end else begin
					state_d = S_CHKHI;
				end
			end
			S_CHKHI: begin
				if (st.gt) begin
					state_d = S_DONE;
					kind_d  = RES_RANGE;
				end else begin
					state_d = S_RYEAR;
				end
			end
			S_RYEAR: begin
				if (!st.gt) state_d = S_RMON;
			end
			S_RMON: begin
				if (!(st.m_lt12 && st.gt)) begin
					state_d = S_DONE;
					kind_d  = RES_OK;
				end
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl.alu        = ALU_HOLD;
		ctl.cal        = CAL_HOLD;
		ctl.bsel       = B_ZERO;
		ctl.wd_clr     = 1'b0;
		ctl.wd_add     = 1'b0;
		ctl.cap_serial = 1'b0;
		ctl.load_out   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					ctl.alu    = ALU_CLR;
					ctl.cal    = CAL_INIT;
					ctl.wd_clr = 1'b1;
				end
			end
			S_FYEAR: begin
				ctl.bsel = B_YLEN;
				if (st.yr_ok && !st.y_eq) begin
					ctl.alu    = ALU_ADD;
					ctl.cal    = CAL_YEAR;
					ctl.wd_add = 1'b1;
				end
			end
			S_FMON: begin
				ctl.bsel = B_MLEN;
				if (st.month_ok && !st.m_eq) begin
					ctl.alu    = ALU_ADD;
					ctl.cal    = CAL_MONTH;
					ctl.wd_add = 1'b1;
				end
			end
			S_FDAY: begin
				ctl.bsel   = B_DAY;
				ctl.alu    = ALU_ADD;
				ctl.wd_add = 1'b1;
			end
			S_OFFS: begin
				ctl.bsel       = B_OFF;
				ctl.alu        = ALU_ADD;
				ctl.cal        = CAL_INIT;
				ctl.cap_serial = 1'b1;
			end
			S_CHKLO: begin
				ctl.bsel = B_ZERO;
			end
			S_CHKHI: begin
				ctl.bsel = B_LAST;
			end
			S_RYEAR: begin
				ctl.bsel = B_YLEN;
				if (st.gt) begin
					ctl.alu = ALU_SUB;
					ctl.cal = CAL_YEAR;
				end
			end
			S_RMON: begin
				ctl.bsel = B_MLEN;
				if (st.m_lt12 && st.gt) begin
					ctl.alu = ALU_SUB;
					ctl.cal = CAL_MONTH;
				end
			end
			S_DONE: begin
				ctl.load_out = out_free;
			end
			default: begin
				ctl.bsel = B_ZERO;
			end
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign kind     = kind_q;

endmodule

// ===== src/gregorian_date_add_days.sv =====
// top level of the Gregorian date shifter
// Checks a date, reports its day serial (1 Jan of BASE_YEAR is 1) and weekday (0 Sunday),
// adds a signed day offset and converts the sum back to a date. One transaction is in
// work at a time; the date is stepped year by year and month by month through a single
// shared add/compare unit, once to build the serial and once to take the shifted serial
// apart. A new request is taken while the previous result still waits on the output side.
`timescale 1ns / 1ps
module gregorian_date_add_days import gdad_pkg::*; #(
	parameter int BASE_YEAR = 1900,
	parameter int YEAR_SPAN = 256
) (
	input logic        clk,
	input logic        arst_n,
	gdad_req_if.sink   req,
	gdad_rsp_if.source rsp
);

	localparam int P_LO = BASE_YEAR - 1;
	localparam int P_HI = BASE_YEAR + YEAR_SPAN - 1;
	localparam int LAST = (P_HI - P_LO) * DAYS_YEAR + P_HI / 4 - P_LO / 4
		- P_HI / 100 + P_LO / 100 + P_HI / 400 - P_LO / 400;
	localparam int AW   = $clog2(LAST + (2 ** 17) + 1) + 1;
	localparam int YW   = $clog2(BASE_YEAR + YEAR_SPAN + 1);
	localparam int YCW  = (YW > 12) ? YW : 12;

	logic [4:0]           day_q;
	logic [3:0]           month_q;
	logic [11:0]          year_q;
	logic signed [17:0]   off_q;
	logic signed [AW-1:0] serial_q;
	logic [2:0]           wd_q;

	logic                 in_fire;
	logic                 out_free;
	ctl_t                 ctl;
	stat_t                st;
	res_kind_t            kind;

	logic signed [AW-1:0] b;
	logic signed [AW-1:0] acc;
	logic                 gt;
	logic [YW-1:0]        cal_year;
	logic [3:0]           cal_month;
	logic                 leap;
	logic [4:0]           mlen;

	logic [2:0]           wd_inc;
	logic [3:0]           wd_sum;

	logic                 out_valid_q;
	logic                 date_valid_q;
	logic [16:0]          serial_day_q;
	logic [2:0]           weekday_q;
	logic [4:0]           result_day_q;
	logic [3:0]           result_month_q;
	logic [11:0]          result_year_q;
	logic                 range_error_q;

	assign in_fire  = req.valid && req.ready;
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			day_q   <= req.day;
			month_q <= req.month;
			year_q  <= req.year;
			off_q   <= req.day_offset;
		end
		if (ctl.cap_serial) serial_q <= acc;
	end

	assign st.yr_ok    = (32'(year_q) >= 32'(BASE_YEAR)) &&
		(32'(year_q) < 32'(BASE_YEAR + YEAR_SPAN));
	assign st.y_eq     = (YCW'(cal_year) == YCW'(year_q));
	assign st.month_ok = (month_q != 4'd0) && (month_q <= MONTHS);
	assign st.m_eq     = (cal_month == month_q);
	assign st.day_ok   = (day_q != 5'd0) && (day_q <= mlen);
	assign st.gt       = gt;
	assign st.m_lt12   = (cal_month < MONTHS);

	always_comb begin
		case (ctl.bsel)
			B_YLEN: begin
				b = leap ? AW'(DAYS_LEAP) : AW'(DAYS_YEAR);
			end
			B_MLEN: begin
				b = AW'(mlen);
			end
			B_DAY: begin
				b = AW'(day_q);
			end
			B_OFF: begin
				b = AW'(off_q);
			end
			B_LAST: begin
				b = AW'(LAST);
			end
			default: begin
				b = '0;
			end
		endcase
	end

	always_comb begin
		case (ctl.bsel)
			B_YLEN: begin
				wd_inc = leap ? 3'd2 : 3'd1;
			end
			B_MLEN: begin
				wd_inc = 3'(mlen - FEB_BASE);
			end
			B_DAY: begin
				wd_inc = DAY_MOD7[day_q];
			end
			default: begin
				wd_inc = 3'd0;
			end
		endcase
	end

	assign wd_sum = {1'b0, wd_q} + {1'b0, wd_inc};

	always_ff @(posedge clk) begin
		if (ctl.wd_clr) begin
			wd_q <= 3'd0;
		end else if (ctl.wd_add) begin
			wd_q <= (wd_sum >= WEEK_DAYS) ? 3'(wd_sum - WEEK_DAYS) : wd_sum[2:0];
		end
	end

	gdad_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.st       (st),
		.ctl      (ctl),
		.in_ready (req.ready),
		.kind     (kind)
	);

	gdad_alu #(
		.AW (AW)
	) u_alu (
		.clk (clk),
		.cmd (ctl.alu),
		.b   (b),
		.acc (acc),
		.gt  (gt)
	);

	gdad_cal #(
		.BASE_YEAR (BASE_YEAR),
		.YEAR_SPAN (YEAR_SPAN)
	) u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (ctl.cal),
		.year   (cal_year),
		.month  (cal_month),
		.leap   (leap),
		.mlen   (mlen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			case (kind)
				RES_OK: begin
					date_valid_q   <= 1'b1;
					serial_day_q   <= 17'(serial_q);
					weekday_q      <= wd_q;
					result_day_q   <= 5'(acc);
					result_month_q <= cal_month;
					result_year_q  <= 12'(cal_year);
					range_error_q  <= 1'b0;
				end
				RES_RANGE: begin
					date_valid_q   <= 1'b1;
					serial_day_q   <= 17'(serial_q);
					weekday_q      <= wd_q;
					result_day_q   <= 5'd0;
					result_month_q <= 4'd0;
					result_year_q  <= 12'd0;
					range_error_q  <= 1'b1;
				end
				default: begin
					date_valid_q   <= 1'b0;
					serial_day_q   <= 17'd0;
					weekday_q      <= 3'd0;
					result_day_q   <= 5'd0;
					result_month_q <= 4'd0;
					result_year_q  <= 12'd0;
					range_error_q  <= 1'b0;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.date_valid   = date_valid_q;
	assign rsp.serial_day   = serial_day_q;
	assign rsp.weekday      = weekday_q;
	assign rsp.result_day   = result_day_q;
	assign rsp.result_month = result_month_q;
	assign rsp.result_year  = result_year_q;
	assign rsp.range_error  = range_error_q;

endmodule
